### sv/mwo_pkg.sv
// Shared types and constants of the morphing wavetable oscillator.
package mwo_pkg;

  // Table geometry; the widths of the slot and address fields follow from it.
  localparam int TableSize  = 1024;
  localparam int SlotCount  = 4;
  localparam int SampleBits = 24;
  localparam int IdxW       = $clog2(TableSize);
  localparam int SlotW      = $clog2(SlotCount);
  localparam int RamDepth   = TableSize * SlotCount;

  // Fixed-point formats: phase Q10.16, morph Q2.10.
  localparam int PhaseFracW = 16;
  localparam int PhaseW     = IdxW + PhaseFracW;
  localparam int IncW       = 26;
  localparam int MorphFracW = 10;
  localparam int MorphW     = 12;
  localparam int CfgDataW   = 26;

  // Depths of the command queue and the result queue.
  localparam int CmdDepth = 4;
  localparam int ResDepth = 2;

  // Configuration register indexes.
  localparam logic [0:0] RegPhaseInc = 1'b0;
  localparam logic [0:0] RegMorph    = 1'b1;

  // Input opcodes.
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_WRITE   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Kinds of work handed from the front end to the back end.
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                     kind;
    logic [PhaseW-1:0]             phase;
    logic [SlotW-1:0]              slot;
    logic [IdxW-1:0]               addr;
    logic signed [SampleBits-1:0]  value;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MC,
    ST_MN,
    ST_MX,
    ST_MF,
    ST_OUT
  } st_e;

endpackage

### sv/mwo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwo_ram #(
  parameter int Width = 24,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/mwo_queue.sv
// Small first-in first-out queue of register entries.
module mwo_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/mwo_front.sv
// Front end: accepts input beats, owns the phase accumulator, queues work.
module mwo_front
  import mwo_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   opcode_i,
  input  logic [SlotW-1:0]             table_slot_i,
  input  logic [IdxW-1:0]              table_address_i,
  input  logic signed [SampleBits-1:0] table_value_i,
  input  logic [IncW-1:0]              phase_inc_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output cmd_t                         q_data_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic              accept;
  op_e               op;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign op     = op_e'(opcode_i);

  // Classify the beat: samples and table writes go to the back end.
  always_comb begin
    q_push_o       = 1'b0;
    q_data_o.kind  = CMD_SAMPLE;
    q_data_o.phase = phase_q;
    q_data_o.slot  = table_slot_i;
    q_data_o.addr  = table_address_i;
    q_data_o.value = table_value_i;
    phase_d        = phase_q;
    case (op)
      OP_SAMPLE: begin
        q_push_o = accept;
        if (accept) begin
          phase_d = phase_q + PhaseW'(phase_inc_i);
        end
      end
      OP_ADVANCE: begin
        if (accept) begin
          phase_d = phase_q + PhaseW'(phase_inc_i);
        end
      end
      OP_WRITE: begin
        q_push_o      = accept;
        q_data_o.kind = CMD_WRITE;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

  // The phase wraps modulo the table length by the width of the register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

### sv/mwo_back.sv
// Back end: table writes, four table reads, interpolation, crossfade, results.
module mwo_back
  import mwo_pkg::*;
#(
  parameter int ResQueueDepth = ResDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  input  logic                         cmd_empty_i,
  output logic                         cmd_pop_o,
  input  logic [MorphW-1:0]            morph_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [SampleBits-1:0] sample_o
);

  localparam int AddrW = $clog2(RamDepth);
  localparam int DiffW = SampleBits + 1;
  localparam int ProdW = DiffW + PhaseFracW + 1;
  localparam int MixW  = DiffW + MorphFracW + 1;

  st_e state_q, state_d;

  logic [IdxW-1:0]              i_q, j_q, head_i;
  logic [PhaseFracW-1:0]        frac_q;
  logic [MorphFracW-1:0]        f_q;
  logic [SlotW-1:0]             cur_q, nxt_q, cur_sel;
  logic signed [SampleBits-1:0] ac_q, bc_q, an_q, wc_q, wn_q;
  logic signed [ProdW-1:0]      prod_q;
  logic signed [MixW-1:0]       mixp_q;

  logic                         ram_we;
  logic [AddrW-1:0]             ram_waddr, ram_raddr;
  logic signed [SampleBits-1:0] rdata;
  logic                         res_push, res_full;
  logic signed [SampleBits-1:0] res_data;
  logic                         start;

  // Interpolation and mix datapath signals.
  logic signed [DiffW-1:0]      d_int, d_mix;
  logic signed [ProdW-1:0]      r16;
  logic signed [SampleBits+1:0] s16, w_sum;
  logic signed [SampleBits-1:0] w_base, w_val;
  logic signed [MixW-1:0]       r10;
  logic signed [SampleBits+1:0] s10, m_sum;

  assign head_i  = cmd_i.phase[PhaseW-1:PhaseFracW];
  assign cur_sel = morph_i[MorphW-1:MorphFracW];
  assign start   = !cmd_empty_i && (cmd_i.kind == CMD_SAMPLE) && !res_full;

  // Next state of the sample sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RD1;
        end
      end
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_MC;
      ST_MC:   state_d = ST_MN;
      ST_MN:   state_d = ST_MX;
      ST_MX:   state_d = ST_MF;
      ST_MF:   state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: queue pop, table write, read address, result push.
  // Read data arrives in the state after its address; the last entry is read again
  // so that it is still on the read port for the next-slot difference.
  always_comb begin
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {cmd_i.slot, cmd_i.addr};
    ram_raddr = '0;
    res_push  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ram_raddr = {cur_sel, head_i};
        if (!cmd_empty_i && cmd_i.kind == CMD_WRITE) begin
          ram_we    = 1'b1;
          cmd_pop_o = 1'b1;
        end else if (start) begin
          cmd_pop_o = 1'b1;
        end
      end
      ST_RD1:  ram_raddr = {cur_q, j_q};
      ST_RD2:  ram_raddr = {nxt_q, i_q};
      ST_RD3:  ram_raddr = {nxt_q, j_q};
      ST_MC:   ram_raddr = {nxt_q, j_q};
      ST_OUT:  res_push = 1'b1;
      default: ram_raddr = '0;
    endcase
  end

  // Difference for the interpolation multiplier: current slot, then next slot.
  always_comb begin
    if (state_q == ST_MC) begin
      d_int = {bc_q[SampleBits-1], bc_q} - {ac_q[SampleBits-1], ac_q};
    end else begin
      d_int = {rdata[SampleBits-1], rdata} - {an_q[SampleBits-1], an_q};
    end
  end

  // Round the registered product and add it to the lower entry.
  assign r16    = prod_q + ProdW'(32768);
  assign s16    = r16[ProdW-1:PhaseFracW];
  assign w_base = (state_q == ST_MN) ? ac_q : an_q;
  assign w_sum  = {{2{w_base[SampleBits-1]}}, w_base} + s16;
  assign w_val  = w_sum[SampleBits-1:0];

  // Crossfade: wc plus the rounded weighted difference toward wn.
  assign d_mix    = {wn_q[SampleBits-1], wn_q} - {wc_q[SampleBits-1], wc_q};
  assign r10      = mixp_q + MixW'(512);
  assign s10      = r10[MixW-1:MorphFracW];
  assign m_sum    = {{2{wc_q[SampleBits-1]}}, wc_q} + s10;
  assign res_data = m_sum[SampleBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      i_q    <= head_i;
      j_q    <= head_i + 1'b1;
      frac_q <= cmd_i.phase[PhaseFracW-1:0];
      cur_q  <= cur_sel;
      nxt_q  <= cur_sel + 1'b1;
      f_q    <= morph_i[MorphFracW-1:0];
    end
    if (state_q == ST_RD1) begin
      ac_q <= rdata;
    end
    if (state_q == ST_RD2) begin
      bc_q <= rdata;
    end
    if (state_q == ST_RD3) begin
      an_q <= rdata;
    end
    if (state_q == ST_MC || state_q == ST_MN) begin
      prod_q <= d_int * $signed({1'b0, frac_q});
    end
    if (state_q == ST_MN) begin
      wc_q <= w_val;
    end
    if (state_q == ST_MX) begin
      wn_q <= w_val;
    end
    if (state_q == ST_MF) begin
      mixp_q <= d_mix * $signed({1'b0, f_q});
    end
  end

  mwo_ram #(
    .Width(SampleBits),
    .Depth(RamDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_i.value),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  mwo_queue #(
    .Width(SampleBits),
    .Depth(ResQueueDepth)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_data),
    .pop_i  (pop),
    .data_o (sample_o),
    .full_o (res_full),
    .empty_o(empty)
  );

  // A sample is only started with room for its result, so a push never meets a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // Commands leave the queue only when one is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop_o |-> !cmd_empty_i)
    else $error("command popped from an empty queue");

  // A sample sequence starts only from idle with a sample command at the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD1) |-> $past(state_q == ST_IDLE && start))
    else $error("sample sequence entered without a start");

endmodule

### sv/morphing_wavetable_oscillator_unit.sv
// Top level of the morphing wavetable oscillator.
//
// Input channel (push/full): one beat carries an opcode and table write
// fields. Sample beats emit one result and advance the phase; advance beats
// only move the phase; table write beats load one entry of one of the four
// table slots; opcode 3 is ignored. A beat is taken when push is high and
// full is low.
// Result channel (empty/pop): the oldest sample waits on sample_o while
// empty is low and leaves when pop is high.
// Configuration: cfg_we_i writes phase increment (index 0) or morph
// position (index 1); write only while the block is idle.
// The back end takes one sample at a time from the head of the command
// queue to the result queue, through the states IDLE, RD1, RD2, RD3, MC,
// MN, MX, MF and OUT, set by four reads through the single table read
// port and the interpolation and crossfade multipliers; a table write
// is done from IDLE, while no sample is in work.
// A four-entry command queue lets input beats arrive while samples are in
// work; when the two-entry result queue fills, sample work waits and
// full eventually rises. Reset clears the phase, the configuration and state
// registers and the queues; table contents are undefined until written.
module morphing_wavetable_oscillator_unit
  import mwo_pkg::*;
#(
  parameter int CmdQueueDepth = CmdDepth,
  parameter int ResQueueDepth = ResDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_index_i,
  input  logic [CfgDataW-1:0]          cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   opcode_i,
  input  logic [SlotW-1:0]             table_slot_i,
  input  logic [IdxW-1:0]              table_address_i,
  input  logic signed [SampleBits-1:0] table_value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [SampleBits-1:0] sample_o
);

  logic [IncW-1:0]   phase_inc_q;
  logic [MorphW-1:0] morph_q;
  logic              q_push, q_full, q_empty, q_pop;
  cmd_t              q_in, q_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= '0;
      morph_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPhaseInc: phase_inc_q <= cfg_data_i[IncW-1:0];
        RegMorph:    morph_q     <= cfg_data_i[MorphW-1:0];
        default:     phase_inc_q <= phase_inc_q;
      endcase
    end
  end

  mwo_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .table_slot_i   (table_slot_i),
    .table_address_i(table_address_i),
    .table_value_i  (table_value_i),
    .phase_inc_i    (phase_inc_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_in)
  );

  mwo_queue #(
    .Width($bits(cmd_t)),
    .Depth(CmdQueueDepth)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .data_o (q_out),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  mwo_back #(
    .ResQueueDepth(ResQueueDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_out),
    .cmd_empty_i(q_empty),
    .cmd_pop_o  (q_pop),
    .morph_i    (morph_q),
    .empty      (empty),
    .pop        (pop),
    .sample_o   (sample_o)
  );

endmodule

### dv/morphing_wavetable_oscillator_unit_tb.sv
// Self-checking testbench of the morphing wavetable oscillator with a built-in predictor.
module morphing_wavetable_oscillator_unit_tb;
  import mwo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One input beat as the sender drives it.
  typedef struct {
    op_e                          op;
    logic [SlotW-1:0]             slot;
    logic [IdxW-1:0]              addr;
    logic signed [SampleBits-1:0] value;
  } beat_t;

  localparam int SettleCycles = 40;
  localparam int RandomPhases = 8;
  localparam int BeatsPerPhase = 112;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [0:0]                   cfg_index = RegPhaseInc;
  logic [CfgDataW-1:0]          cfg_data = '0;
  logic                         push = 1'b0;
  logic                         full;
  logic                         empty;
  logic                         pop = 1'b0;
  logic signed [SampleBits-1:0] sample_o;
  beat_t                        cur_beat = '{OP_NONE, '0, '0, '0};

  // Oscillator state as predicted by the testbench.
  logic [PhaseW-1:0]            osc_phase = '0;
  logic [IncW-1:0]              step_reg = '0;
  logic [MorphW-1:0]            morph_reg = '0;
  logic signed [SampleBits-1:0] wave_mem [RamDepth];

  // Phase as the queued beats will leave it, and entries that queued beats write.
  logic [PhaseW-1:0]            plan_phase = '0;
  bit                           loaded [RamDepth];

  // Pending input beats and expected samples.
  beat_t                        beat_q[$];
  logic signed [SampleBits-1:0] sample_q[$];
  logic signed [SampleBits-1:0] want;

  logic       in_taken = 1'b0;
  int         gap_left = 0;
  int         burst_left = 1;
  logic [15:0] pop_pat = 16'hffff;
  logic [5:0] pop_cnt = '0;
  int         fail_count = 0;
  int         checked_count = 0;
  int         op_count [4] = '{0, 0, 0, 0};

  morphing_wavetable_oscillator_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push           (push),
    .full           (full),
    .opcode_i       (cur_beat.op),
    .table_slot_i   (cur_beat.slot),
    .table_address_i(cur_beat.addr),
    .table_value_i  (cur_beat.value),
    .empty          (empty),
    .pop            (pop),
    .sample_o       (sample_o)
  );

  always #2 clk = ~clk;

  // Linear interpolation inside one slot between entries i and j at fraction p.
  function automatic longint lerp_entry(logic [SlotW-1:0] s, logic [IdxW-1:0] i,
                                        logic [IdxW-1:0] j, longint p);
    longint a;
    longint b;
    a = wave_mem[{s, i}];
    b = wave_mem[{s, j}];
    return a + (((b - a) * p + 32768) >>> PhaseFracW);
  endfunction

  // Apply one accepted beat to the predicted state; sample beats queue a result.
  task automatic predict_beat(input beat_t b);
    logic [IdxW-1:0]  i;
    logic [IdxW-1:0]  j;
    logic [SlotW-1:0] cur;
    logic [SlotW-1:0] nxt;
    longint           p;
    longint           f;
    longint           wc;
    longint           wn;
    longint           mix;
    case (b.op)
      OP_WRITE: wave_mem[{b.slot, b.addr}] = b.value;
      OP_ADVANCE: osc_phase = osc_phase + step_reg;
      OP_SAMPLE: begin
        i = osc_phase[PhaseW-1:PhaseFracW];
        // The entry after the last one wraps to entry 0.
        j = i + 1'b1;
        p = osc_phase[PhaseFracW-1:0];
        cur = morph_reg[MorphW-1:MorphFracW];
        nxt = cur + 1'b1;
        f = morph_reg[MorphFracW-1:0];
        wc = lerp_entry(cur, i, j, p);
        wn = lerp_entry(nxt, i, j, p);
        mix = (wc * (1024 - f) + wn * f + 512) >>> MorphFracW;
        sample_q.push_back(mix[SampleBits-1:0]);
        osc_phase = osc_phase + step_reg;
      end
      default: ;
    endcase
  endtask

  // Sample both channels at the rising edge: check results, then predict.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (sample_q.size() == 0) begin
        $error("unexpected sample beat: got %0d", sample_o);
        fail_count++;
      end else begin
        want = sample_q.pop_front();
        checked_count++;
        if (sample_o !== want) begin
          $error("sample mismatch: expected %0d, actual %0d", want, sample_o);
          fail_count++;
        end
      end
    end
    if (rst_n && push && !full) begin
      op_count[cur_beat.op]++;
      predict_beat(cur_beat);
    end
    in_taken <= rst_n && push && !full;
  end

  // Sender in bursts with random gaps; receiver on a rotating stall pattern.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!push || in_taken) begin
        if (gap_left != 0) begin
          push <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (beat_q.size() != 0) begin
          cur_beat <= beat_q.pop_front();
          push <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
      pop <= pop_pat[0];
      pop_cnt <= pop_cnt + 1'b1;
      if (pop_cnt == '0) begin
        case ($urandom_range(0, 3))
          0: pop_pat <= 16'hffff;
          1: pop_pat <= 16'h0001;
          default: pop_pat <= 16'($urandom()) | 16'h8000;
        endcase
      end else begin
        pop_pat <= {pop_pat[0], pop_pat[15:1]};
      end
    end
  end

  // Table values with the extremes well represented.
  function automatic logic signed [SampleBits-1:0] pick_value();
    case ($urandom_range(0, 15))
      0, 1: return {1'b0, {(SampleBits-1){1'b1}}};
      2, 3: return {1'b1, {(SampleBits-1){1'b0}}};
      4: return '0;
      5: return '1;
      default: return SampleBits'($urandom());
    endcase
  endfunction

  // Queue a write of a random value to an entry that no queued beat has written yet.
  task automatic fill_entry(input logic [SlotW-1:0] s, input logic [IdxW-1:0] a);
    if (!loaded[{s, a}]) begin
      loaded[{s, a}] = 1'b1;
      beat_q.push_back('{OP_WRITE, s, a, pick_value()});
    end
  endtask

  // Queue one beat; a sample is preceded by writes of any entry it reads unloaded.
  task automatic add_beat(input op_e op, input logic [SlotW-1:0] slot,
                          input logic [IdxW-1:0] addr,
                          input logic signed [SampleBits-1:0] value);
    logic [IdxW-1:0]  i;
    logic [IdxW-1:0]  j;
    logic [SlotW-1:0] cur;
    logic [SlotW-1:0] nxt;
    if (op == OP_SAMPLE) begin
      i = plan_phase[PhaseW-1:PhaseFracW];
      j = i + 1'b1;
      cur = morph_reg[MorphW-1:MorphFracW];
      nxt = cur + 1'b1;
      fill_entry(cur, i);
      fill_entry(cur, j);
      fill_entry(nxt, i);
      fill_entry(nxt, j);
    end
    if (op == OP_WRITE) begin
      loaded[{slot, addr}] = 1'b1;
    end
    if (op == OP_SAMPLE || op == OP_ADVANCE) begin
      plan_phase = plan_phase + step_reg;
    end
    beat_q.push_back('{op, slot, addr, value});
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_reg(input logic [0:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == RegPhaseInc) begin
      step_reg = val[IncW-1:0];
    end else begin
      morph_reg = val[MorphW-1:0];
    end
  endtask

  // Wait until every beat is sent and every sample has come back.
  task automatic settle();
    while (beat_q.size() != 0 || push || sample_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [IncW-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return IncW'(1);
      2: return 26'h000ffff;
      3: return 26'h0010000;
      4: return '1;
      5: return 26'h2000000;
      6: return IncW'($urandom_range(0, 26'h003ffff));
      default: return IncW'($urandom());
    endcase
  endfunction

  function automatic logic [MorphW-1:0] pick_morph();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 12'd1023;
      2: return 12'd1024;
      3: return 12'd3072;
      4: return '1;
      default: return MorphW'($urandom());
    endcase
  endfunction

  // Stimulus sequence.
  initial begin
    int r;
    beat_t b;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: sample at phase zero, then the next-entry wrap between
    // entries 1023 and 0 with full-scale steps, and an ignored opcode.
    write_reg(RegPhaseInc, 26'h3ff8000);
    write_reg(RegMorph, '0);
    add_beat(OP_SAMPLE, '0, '0, '0);
    add_beat(OP_WRITE, 2'd0, 10'd1023, {1'b0, {(SampleBits-1){1'b1}}});
    add_beat(OP_WRITE, 2'd0, 10'd0, {1'b1, {(SampleBits-1){1'b0}}});
    add_beat(OP_WRITE, 2'd1, 10'd1023, {1'b1, {(SampleBits-1){1'b0}}});
    add_beat(OP_WRITE, 2'd1, 10'd0, {1'b0, {(SampleBits-1){1'b1}}});
    add_beat(OP_WRITE, 2'd3, 10'd1023, {1'b1, {(SampleBits-1){1'b0}}});
    add_beat(OP_WRITE, 2'd3, 10'd0, {1'b0, {(SampleBits-1){1'b1}}});
    add_beat(OP_ADVANCE, '1, '1, '1);
    add_beat(OP_SAMPLE, '1, '1, '1);
    add_beat(OP_NONE, '1, '1, '1);
    add_beat(OP_SAMPLE, '0, '0, '0);
    add_beat(OP_SAMPLE, '0, '0, '0);
    settle();

    // Directed: largest increment, and a morph past three fading slot 3 into slot 0.
    write_reg(RegPhaseInc, '1);
    write_reg(RegMorph, 12'd3584);
    add_beat(OP_SAMPLE, '0, '0, '0);
    add_beat(OP_SAMPLE, '0, '0, '0);
    add_beat(OP_ADVANCE, '0, '0, '0);
    add_beat(OP_SAMPLE, '0, '0, '0);
    add_beat(OP_NONE, '0, '0, '0);
    add_beat(OP_SAMPLE, '0, '0, '0);
    settle();

    // Directed: top morph value with the largest fraction.
    write_reg(RegPhaseInc, 26'h000ffff);
    write_reg(RegMorph, {{(CfgDataW-MorphW){1'b1}}, 12'hfff});
    add_beat(OP_SAMPLE, '0, '0, '0);
    add_beat(OP_SAMPLE, '0, '0, '0);
    add_beat(OP_SAMPLE, '0, '0, '0);
    settle();

    // Random phases, each with its own register settings.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(RegPhaseInc, CfgDataW'(pick_step()));
        write_reg(RegMorph, {CfgDataW'($urandom()) & ~CfgDataW'(12'hfff)} | pick_morph());
      end else begin
        write_reg(RegMorph, CfgDataW'(pick_morph()));
        write_reg(RegPhaseInc, CfgDataW'(pick_step()));
      end
      while (beat_q.size() < BeatsPerPhase) begin
        r = $urandom_range(0, 99);
        b.op = (r < 55) ? OP_SAMPLE : (r < 70) ? OP_ADVANCE : (r < 95) ? OP_WRITE : OP_NONE;
        b.slot = SlotW'($urandom());
        b.addr = IdxW'($urandom());
        b.value = pick_value();
        add_beat(b.op, b.slot, b.addr, b.value);
      end
      settle();
    end

    $display("Checked %0d samples; beats sent: %0d sample, %0d advance, %0d write, %0d unused.",
             checked_count, op_count[OP_SAMPLE], op_count[OP_ADVANCE],
             op_count[OP_WRITE], op_count[OP_NONE]);
    $display("Covered %0d random register settings plus directed wrap and morph cases.",
             RandomPhases);
    if (fail_count == 0) begin
      $display("PASS morphing_wavetable_oscillator_unit");
    end else begin
      $display("FAIL morphing_wavetable_oscillator_unit");
    end
    $finish;
  end

  // Watchdog against a hung block.
  initial begin
    #2_000_000;
    $display("FAIL morphing_wavetable_oscillator_unit");
    $finish;
  end

endmodule
